/* rtl/msrf_pkg.sv */
// ----------------------------------------------------------------------------
// msrf_pkg
// Types and codes shared by the message slot ring FIFO modules.
// ----------------------------------------------------------------------------
package msrf_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 7;

  // operation code of an input transaction
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_READ_DATA = 3'd0,
    ST_WRITE_OK  = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD_LEN   = 3'd4
  } status_e;

  // fault recorded against the message being written
  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_FULL = 2'd1,
    FAULT_LONG = 2'd2
  } fault_e;

  // command class decided by the front end
  typedef enum logic [1:0] {
    CMD_WR_BYTE = 2'd0,
    CMD_WR_LAST = 2'd1,
    CMD_RD      = 2'd2,
    CMD_RD_BAD  = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    op_e                operation;
    logic [BYTE_W-1:0]  data_byte;
    logic               end_of_message;
    logic [LIMIT_W-1:0] read_limit;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_byte;
    logic               last_in_run;
    status_e            status;
    logic [LIMIT_W-1:0] returned_length;
    logic               space_available;
    logic               data_available;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [LIMIT_W-1:0] read_limit;
  } cmd_t;

endpackage

/* rtl/msrf_ram.sv */
// ----------------------------------------------------------------------------
// msrf_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module msrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/msrf_front.sv */
// ----------------------------------------------------------------------------
// msrf_front
// Accepts input transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module msrf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  msrf_pkg::in_item_t in_data_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output msrf_pkg::cmd_t    cmd_o
);

  localparam int unsigned QDEPTH = 2;

  msrf_pkg::cmd_t fq_q [QDEPTH];
  msrf_pkg::cmd_t cls;
  logic           wptr_q, wptr_d;
  logic           rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;

  // classify the incoming transaction
  always_comb begin
    cls.data_byte  = in_data_i.data_byte;
    cls.read_limit = in_data_i.read_limit;
    if (in_data_i.operation == msrf_pkg::OP_READ) begin
      cls.kind = (in_data_i.read_limit == '0) ? msrf_pkg::CMD_RD_BAD : msrf_pkg::CMD_RD;
    end else begin
      cls.kind = in_data_i.end_of_message ? msrf_pkg::CMD_WR_LAST : msrf_pkg::CMD_WR_BYTE;
    end
  end

  assign in_ready_o  = (cnt_q != 2'(QDEPTH));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fq_q[rptr_q];

  // queue pointers
  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fq_q[wptr_q] <= cls;
    end
  end

endmodule

/* rtl/msrf_back.sv */
// ----------------------------------------------------------------------------
// msrf_back
// Executes queued commands against the slot ring and queues the results.
// ----------------------------------------------------------------------------
module msrf_back #(
  parameter int unsigned SLOT_COUNT = 8,
  parameter int unsigned SLOT_BYTES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  msrf_pkg::cmd_t     cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output msrf_pkg::out_item_t out_data_o
);

  localparam int unsigned SW       = $clog2(SLOT_COUNT);
  localparam int unsigned OW       = $clog2(SLOT_COUNT + 1);
  localparam int unsigned CW       = $clog2(SLOT_BYTES + 2);
  localparam int unsigned LW       = $clog2(SLOT_BYTES + 1);
  localparam int unsigned BDEPTH   = SLOT_COUNT * SLOT_BYTES;
  localparam int unsigned AW       = $clog2(BDEPTH);
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned QPW      = $clog2(OQ_DEPTH);
  localparam int unsigned QCW      = $clog2(OQ_DEPTH + 2);
  localparam int unsigned LIMW     = msrf_pkg::LIMIT_W;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_RD_LEN  = 3'b010,
    S_RD_DATA = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [SW-1:0]      rslot_q, rslot_d;
  logic [SW-1:0]      wslot_q, wslot_d;
  logic [SW-1:0]      cur_slot_q, cur_slot_d;
  logic [OW-1:0]      occ_q, occ_d;
  logic [CW-1:0]      pcnt_q, pcnt_d;
  msrf_pkg::fault_e   pfault_q, pfault_d;
  logic [LIMW-1:0]    limit_q, limit_d;
  logic [LW-1:0]      n_q, n_d;
  logic [LW-1:0]      idx_q, idx_d;
  logic               infl_q, infl_d;
  logic               infl_last_q, infl_last_d;

  // command decode and write path
  logic               cmd_take;
  logic               wr_go, wr_end, rd_go, rd_bad;
  msrf_pkg::fault_e   wr_fault;
  logic [CW-1:0]      wr_cnt_n;
  logic               st_push;
  msrf_pkg::status_e  st_code;
  logic               issue_ok;
  logic [LIMW-1:0]    len_ext, n_ext;

  // memory ports
  logic               bram_we, bram_re;
  logic [AW-1:0]      bram_waddr, bram_raddr;
  logic [msrf_pkg::BYTE_W-1:0] bram_rdata;
  logic               lram_we, lram_re;
  logic [LW-1:0]      lram_rdata;

  // output queue
  msrf_pkg::out_item_t oq_q [OQ_DEPTH];
  msrf_pkg::out_item_t push_item;
  logic [QPW-1:0]     oq_wptr_q, oq_rptr_q;
  logic [QCW-1:0]     oq_cnt_q;
  logic               oq_push, oq_pop;

  assign cmd_ready_o = (state_q == S_IDLE) && !infl_q && (oq_cnt_q < QCW'(OQ_DEPTH));
  assign cmd_take    = cmd_valid_i && cmd_ready_o;
  assign issue_ok    = (oq_cnt_q + QCW'(infl_q)) < QCW'(OQ_DEPTH);

  assign bram_waddr = AW'(wslot_q) * AW'(SLOT_BYTES) + AW'(pcnt_q);
  assign bram_raddr = AW'(cur_slot_q) * AW'(SLOT_BYTES) + AW'(idx_q);

  // returned count is the stored length cut to the limit
  assign len_ext = LIMW'(lram_rdata);
  assign n_ext   = (len_ext < limit_q) ? len_ext : limit_q;

  // command class
  always_comb begin
    wr_go  = 1'b0;
    wr_end = 1'b0;
    rd_go  = 1'b0;
    rd_bad = 1'b0;
    case (cmd_i.kind)
      msrf_pkg::CMD_WR_BYTE: wr_go = 1'b1;
      msrf_pkg::CMD_WR_LAST: begin
        wr_go  = 1'b1;
        wr_end = 1'b1;
      end
      msrf_pkg::CMD_RD:      rd_go = 1'b1;
      msrf_pkg::CMD_RD_BAD:  rd_bad = 1'b1;
      default: ;
    endcase
  end

  // fault tracking and byte count of the message being written
  always_comb begin
    wr_fault = pfault_q;
    if (pcnt_q == '0 && occ_q == OW'(SLOT_COUNT)) begin
      wr_fault = msrf_pkg::FAULT_FULL;
    end
    if (pcnt_q >= CW'(SLOT_BYTES) && wr_fault == msrf_pkg::FAULT_NONE) begin
      wr_fault = msrf_pkg::FAULT_LONG;
    end
    wr_cnt_n = (pcnt_q <= CW'(SLOT_BYTES)) ? pcnt_q + 1'b1 : pcnt_q;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    rslot_d     = rslot_q;
    wslot_d     = wslot_q;
    cur_slot_d  = cur_slot_q;
    occ_d       = occ_q;
    pcnt_d      = pcnt_q;
    pfault_d    = pfault_q;
    limit_d     = limit_q;
    n_d         = n_q;
    idx_d       = idx_q;
    infl_d      = 1'b0;
    infl_last_d = 1'b0;
    bram_we     = 1'b0;
    bram_re     = 1'b0;
    lram_we     = 1'b0;
    lram_re     = 1'b0;
    st_push     = 1'b0;
    st_code     = msrf_pkg::ST_READ_DATA;
    case (state_q)
      S_IDLE: begin
        if (cmd_take && wr_go) begin
          bram_we  = (pcnt_q < CW'(SLOT_BYTES)) && (wr_fault == msrf_pkg::FAULT_NONE);
          pcnt_d   = wr_cnt_n;
          pfault_d = wr_fault;
          if (wr_end) begin
            st_push  = 1'b1;
            pcnt_d   = '0;
            pfault_d = msrf_pkg::FAULT_NONE;
            case (wr_fault)
              msrf_pkg::FAULT_FULL: st_code = msrf_pkg::ST_FULL;
              msrf_pkg::FAULT_LONG: st_code = msrf_pkg::ST_BAD_LEN;
              default: begin
                st_code = msrf_pkg::ST_WRITE_OK;
                lram_we = 1'b1;
                wslot_d = (wslot_q == SW'(SLOT_COUNT - 1)) ? '0 : wslot_q + 1'b1;
                occ_d   = occ_q + 1'b1;
              end
            endcase
          end
        end else if (cmd_take && (rd_go || rd_bad)) begin
          if (occ_q == '0) begin
            st_push = 1'b1;
            st_code = msrf_pkg::ST_EMPTY;
          end else if (rd_bad) begin
            st_push = 1'b1;
            st_code = msrf_pkg::ST_BAD_LEN;
          end else begin
            lram_re    = 1'b1;
            limit_d    = cmd_i.read_limit;
            cur_slot_d = rslot_q;
            state_d    = S_RD_LEN;
          end
        end
      end
      S_RD_LEN: begin
        // length is back: fix the count and release the slot
        n_d     = LW'(n_ext);
        idx_d   = '0;
        rslot_d = (rslot_q == SW'(SLOT_COUNT - 1)) ? '0 : rslot_q + 1'b1;
        occ_d   = occ_q - 1'b1;
        state_d = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (issue_ok) begin
          bram_re     = 1'b1;
          infl_d      = 1'b1;
          infl_last_d = (idx_q == n_q - 1'b1);
          idx_d       = idx_q + 1'b1;
          if (idx_q == n_q - 1'b1) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rslot_q     <= '0;
      wslot_q     <= '0;
      occ_q       <= '0;
      pcnt_q      <= '0;
      pfault_q    <= msrf_pkg::FAULT_NONE;
      infl_q      <= 1'b0;
      infl_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rslot_q     <= rslot_d;
      wslot_q     <= wslot_d;
      occ_q       <= occ_d;
      pcnt_q      <= pcnt_d;
      pfault_q    <= pfault_d;
      infl_q      <= infl_d;
      infl_last_q <= infl_last_d;
    end
  end

  // read context, held for the whole read
  always_ff @(posedge clk_i) begin
    cur_slot_q <= cur_slot_d;
    limit_q    <= limit_d;
    n_q        <= n_d;
    idx_q      <= idx_d;
  end

  // message byte store
  msrf_ram #(
    .WIDTH(msrf_pkg::BYTE_W),
    .DEPTH(BDEPTH)
  ) u_byte_ram (
    .clk_i  (clk_i),
    .we_i   (bram_we),
    .waddr_i(bram_waddr),
    .wdata_i(cmd_i.data_byte),
    .re_i   (bram_re),
    .raddr_i(bram_raddr),
    .rdata_o(bram_rdata)
  );

  // per-slot length store
  msrf_ram #(
    .WIDTH(LW),
    .DEPTH(SLOT_COUNT)
  ) u_len_ram (
    .clk_i  (clk_i),
    .we_i   (lram_we),
    .waddr_i(wslot_q),
    .wdata_i(LW'(wr_cnt_n)),
    .re_i   (lram_re),
    .raddr_i(rslot_q),
    .rdata_o(lram_rdata)
  );

  // result assembly: in-flight read data first, else a status result
  always_comb begin
    push_item = '0;
    if (infl_q) begin
      push_item.read_byte       = bram_rdata;
      push_item.last_in_run     = infl_last_q;
      push_item.status          = msrf_pkg::ST_READ_DATA;
      push_item.returned_length = LIMW'(n_q);
      push_item.space_available = (occ_q < OW'(SLOT_COUNT));
      push_item.data_available  = (occ_q != '0);
    end else begin
      push_item.last_in_run     = 1'b1;
      push_item.status          = st_code;
      push_item.space_available = (occ_d < OW'(SLOT_COUNT));
      push_item.data_available  = (occ_d != '0);
    end
  end

  assign oq_push     = infl_q || st_push;
  assign out_valid_o = (oq_cnt_q != '0);
  assign oq_pop      = out_valid_o && out_ready_i;
  assign out_data_o  = oq_q[oq_rptr_q];

  // output queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wptr_q <= '0;
      oq_rptr_q <= '0;
      oq_cnt_q  <= '0;
    end else begin
      if (oq_push) begin
        oq_wptr_q <= oq_wptr_q + 1'b1;
      end
      if (oq_pop) begin
        oq_rptr_q <= oq_rptr_q + 1'b1;
      end
      oq_cnt_q <= oq_cnt_q + QCW'(oq_push) - QCW'(oq_pop);
    end
  end

  // output queue storage
  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_q[oq_wptr_q] <= push_item;
    end
  end

  // results never land in a full output queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_push |-> (oq_cnt_q < QCW'(OQ_DEPTH)))
    else $error("output queue overflow");

  // occupancy stays within the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(SLOT_COUNT))
    else $error("occupied count out of range");

  // read data only arrives after a byte fetch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    infl_q |-> $past(state_q == S_RD_DATA))
    else $error("read data without a fetch");

  // a read that streams bytes returns at least one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_DATA) |-> (n_q != '0))
    else $error("zero-length read stream");

  // a fault is only ever held within a message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pfault_q != msrf_pkg::FAULT_NONE) |-> (pcnt_q != '0))
    else $error("fault held outside a message");

endmodule

/* rtl/message_slot_ring_fifo_top.sv */
// Message slot ring FIFO. Messages are written one byte per transaction and
// land in a ring of SLOT_COUNT slots of SLOT_BYTES bytes; a read transaction
// returns the oldest message cut to its byte limit, one byte per result, and
// frees the slot. Write bytes are taken one per cycle while the back end is
// idle with no read byte in flight and room in the output queue. A read of
// n bytes fetches the slot length, fixes the count, makes n fetches through
// the single read port of the byte RAM as room in the output queue allows,
// and lands the last byte in flight. A front queue of two commands and an
// output queue of four results let input and output stall independently.
// ----------------------------------------------------------------------------
// message_slot_ring_fifo_top
// Top level of the message slot ring FIFO: front end, back end and queues.
// ----------------------------------------------------------------------------
module message_slot_ring_fifo_top #(
  parameter int unsigned SLOT_COUNT = 8,
  parameter int unsigned SLOT_BYTES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  msrf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output msrf_pkg::out_item_t out_data_o
);

  logic           cmd_valid;
  logic           cmd_ready;
  msrf_pkg::cmd_t cmd;

  // accept and classify
  msrf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  // execute against the slot ring
  msrf_back #(
    .SLOT_COUNT(SLOT_COUNT),
    .SLOT_BYTES(SLOT_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

/* dv/tb_message_slot_ring_fifo_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_message_slot_ring_fifo_top
// Self-checking bench for the message slot ring FIFO. Byte-wise message writes
// and whole-message reads are queued, driven through the valid/ready input
// channel, and mirrored by a behavioral slot ring that predicts every result.
// Each output transaction is compared against the oldest prediction while
// both channels idle and stall at varying rates.
// ----------------------------------------------------------------------------
module tb_message_slot_ring_fifo_top;

  localparam int unsigned SLOT_COUNT = 8;
  localparam int unsigned SLOT_BYTES = 64;
  localparam int unsigned PHASE_ITEMS = 100;
  localparam int unsigned DRAIN_CYCLES = 120;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  msrf_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  msrf_pkg::out_item_t out_item;

  // stimulus and prediction stores
  msrf_pkg::in_item_t  outgoing_items[$];
  msrf_pkg::out_item_t predicted_results[$];
  int unsigned items_pushed;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count = 0;

  // behavioral copy of the slot ring
  logic [7:0]       slot_mem [SLOT_COUNT][SLOT_BYTES];
  logic [6:0]       slot_len [SLOT_COUNT];
  int unsigned      rd_slot = 0;
  int unsigned      wr_slot = 0;
  int unsigned      occ_cnt = 0;
  int unsigned      pend_cnt = 0;
  msrf_pkg::fault_e pend_fault = msrf_pkg::FAULT_NONE;

  message_slot_ring_fifo_top #(
    .SLOT_COUNT(SLOT_COUNT),
    .SLOT_BYTES(SLOT_BYTES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_item)
  );

  // clock and reset
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // results caused by one accepted input transaction
  task automatic predict_ring_results(input msrf_pkg::in_item_t item);
    msrf_pkg::out_item_t run[$];
    msrf_pkg::out_item_t res;
    int unsigned n;
    begin
      res = '0;
      if (item.operation == msrf_pkg::OP_WRITE) begin
        // first byte of a message sees a full ring
        if (pend_cnt == 0 && occ_cnt >= SLOT_COUNT) pend_fault = msrf_pkg::FAULT_FULL;
        if (pend_cnt < SLOT_BYTES) begin
          if (pend_fault == msrf_pkg::FAULT_NONE)
            slot_mem[wr_slot][pend_cnt] = item.data_byte;
        end else if (pend_fault == msrf_pkg::FAULT_NONE) begin
          pend_fault = msrf_pkg::FAULT_LONG;
        end
        if (pend_cnt <= SLOT_BYTES) pend_cnt++;
        if (item.end_of_message) begin
          res.last_in_run = 1'b1;
          case (pend_fault)
            msrf_pkg::FAULT_FULL: begin
              res.status = msrf_pkg::ST_FULL;
            end
            msrf_pkg::FAULT_LONG: begin
              res.status = msrf_pkg::ST_BAD_LEN;
            end
            default: begin
              slot_len[wr_slot] = pend_cnt[6:0];
              wr_slot = (wr_slot + 1) % SLOT_COUNT;
              occ_cnt++;
              res.status = msrf_pkg::ST_WRITE_OK;
            end
          endcase
          run.push_back(res);
          pend_cnt = 0;
          pend_fault = msrf_pkg::FAULT_NONE;
        end
      end else if (occ_cnt == 0) begin
        // empty check wins over the limit check
        res.last_in_run = 1'b1;
        res.status = msrf_pkg::ST_EMPTY;
        run.push_back(res);
      end else if (item.read_limit == 0) begin
        res.last_in_run = 1'b1;
        res.status = msrf_pkg::ST_BAD_LEN;
        run.push_back(res);
      end else begin
        // oldest message, cut to the limit
        n = slot_len[rd_slot];
        if (n > SLOT_BYTES) n = SLOT_BYTES;
        if (n > item.read_limit) n = item.read_limit;
        for (int unsigned i = 0; i < n; i++) begin
          res.read_byte = slot_mem[rd_slot][i];
          res.last_in_run = (i + 1 == n);
          res.status = msrf_pkg::ST_READ_DATA;
          res.returned_length = n[6:0];
          run.push_back(res);
        end
        rd_slot = (rd_slot + 1) % SLOT_COUNT;
        occ_cnt--;
      end
      // flags reflect the state after the whole transaction
      foreach (run[k]) begin
        run[k].space_available = (occ_cnt < SLOT_COUNT);
        run[k].data_available = (occ_cnt > 0);
        predicted_results.push_back(run[k]);
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input msrf_pkg::out_item_t want,
                               input msrf_pkg::out_item_t got);
    begin
      err_count++;
      if (err_count <= 10) begin
        $display("%0t: %s: expected byte=%0d last=%0d status=%0d len=%0d space=%0d data=%0d",
                 $realtime, what, want.read_byte, want.last_in_run, want.status,
                 want.returned_length, want.space_available, want.data_available);
        $display("%0t: %s:   actual byte=%0d last=%0d status=%0d len=%0d space=%0d data=%0d",
                 $realtime, what, got.read_byte, got.last_in_run, got.status,
                 got.returned_length, got.space_available, got.data_available);
      end
    end
  endtask

  // input driver: holds each transaction until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (outgoing_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_item <= outgoing_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    msrf_pkg::out_item_t want;
    if (rst_ni) begin
      if (in_valid && in_ready) predict_ring_results(in_item);
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          flag_mismatch("unexpected result", '0, out_item);
        end else begin
          want = predicted_results.pop_front();
          if (out_item.read_byte !== want.read_byte ||
              out_item.last_in_run !== want.last_in_run ||
              out_item.status !== want.status ||
              out_item.returned_length !== want.returned_length ||
              out_item.space_available !== want.space_available ||
              out_item.data_available !== want.data_available) begin
            flag_mismatch("result mismatch", want, out_item);
          end
        end
      end
    end
  end

  // stimulus builders
  task automatic push_write_byte(input logic [7:0] b, input logic eom);
    msrf_pkg::in_item_t item;
    begin
      item.operation = msrf_pkg::OP_WRITE;
      item.data_byte = b;
      item.end_of_message = eom;
      item.read_limit = 7'($urandom_range(64));
      outgoing_items.push_back(item);
      items_pushed++;
    end
  endtask

  task automatic push_read(input logic [6:0] lim);
    msrf_pkg::in_item_t item;
    begin
      item.operation = msrf_pkg::OP_READ;
      item.data_byte = 8'($urandom);
      item.end_of_message = 1'($urandom);
      item.read_limit = lim;
      outgoing_items.push_back(item);
      items_pushed++;
    end
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 78) return $urandom_range(8, 1);
    if (r < 91) return $urandom_range(63, 9);
    if (r < 96) return SLOT_BYTES;
    return $urandom_range(SLOT_BYTES + 6, SLOT_BYTES + 1);
  endfunction

  function automatic logic [6:0] pick_limit();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 7'd0;
    if (r < 16) return 7'(SLOT_BYTES);
    if (r < 40) return 7'($urandom_range(3, 1));
    return 7'($urandom_range(64, 1));
  endfunction

  task automatic push_message(input int unsigned msg_len, input bit mid_read);
    int unsigned split;
    begin
      split = $urandom_range(msg_len - 1);
      for (int unsigned i = 0; i < msg_len; i++) begin
        // read slipped in while the message is still open
        if (mid_read && i == split && i != 0) push_read(pick_limit());
        push_write_byte(8'($urandom), i + 1 == msg_len);
      end
    end
  endtask

  task automatic push_random_scenario();
    int unsigned sel;
    msrf_pkg::in_item_t item;
    begin
      sel = $urandom_range(99);
      if (sel < 38) begin
        push_message(pick_length(), 1'b0);
      end else if (sel < 70) begin
        push_read(pick_limit());
      end else if (sel < 78) begin
        // burst of short messages to reach a full ring
        repeat ($urandom_range(10, 4)) push_message($urandom_range(3, 1), 1'b0);
      end else if (sel < 86) begin
        // burst of reads to drain the ring
        repeat ($urandom_range(10, 4)) push_read(pick_limit());
      end else if (sel < 94) begin
        push_message($urandom_range(8, 2), 1'b1);
      end else begin
        // noise: fully random fields
        item = msrf_pkg::in_item_t'($urandom);
        item.operation = msrf_pkg::op_e'($urandom_range(1));
        item.read_limit = 7'($urandom_range(64));
        outgoing_items.push_back(item);
        items_pushed++;
      end
    end
  endtask

  // directed cases: empty, zero limit, truncation, read inside a write, full
  task automatic push_directed();
    begin
      push_read(7'd0);
      push_read(7'd64);
      push_write_byte(8'hFF, 1'b1);
      push_read(7'd0);
      push_read(7'd64);
      push_write_byte(8'h00, 1'b0);
      push_write_byte(8'hAA, 1'b0);
      push_write_byte(8'h55, 1'b1);
      push_read(7'd2);
      push_write_byte(8'h80, 1'b0);
      push_write_byte(8'h7F, 1'b1);
      push_write_byte(8'h01, 1'b0);
      push_read(7'd64);
      push_write_byte(8'hFE, 1'b1);
      push_read(7'd1);
      repeat (SLOT_COUNT) push_write_byte(8'($urandom), 1'b1);
      push_write_byte(8'h3C, 1'b1);
    end
  endtask

  // phase sequencing and end of test
  initial begin
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    idle_tab = '{0, 85, 0, 14};
    stall_tab = '{0, 0, 85, 14};
    @(posedge rst_ni);
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_tab[p];
      recv_stall_pct = stall_tab[p];
      if (p == 0) push_directed();
      items_pushed = 0;
      while (items_pushed < PHASE_ITEMS) push_random_scenario();
      while (outgoing_items.size() != 0 || in_valid || predicted_results.size() != 0)
        @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (predicted_results.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
